// ----- rtl/core/q2e_pkg.sv -----
// Shared types, constants and helper functions of the quaternion to Euler converter.
`default_nettype none

package q2e_pkg;

    localparam int QUAT_W    = 16;  // width of one quaternion component
    localparam int PROD_W    = 32;  // width of one component product
    localparam int Q13_W     = 16;  // width of a Q2.13 angle
    localparam int PITCH_W   = 15;  // width of the pitch result
    localparam int ZW        = 35;  // Q30 angle accumulator width
    localparam int CW        = 34;  // CORDIC x/y datapath width
    localparam int NORM_PAD  = 28;  // zero bits appended below a magnitude before normalising
    localparam int NORM_W    = 30;  // normalised magnitudes sit in [2^29, 2^30)
    localparam int ARC_LEN   = 24;  // entries in the arctangent table
    localparam int S30_W     = 32;  // pitch sine term in Q30
    localparam int SQRT_BITS = 31;  // root digits, one per stage
    localparam int RAD_W     = 61;  // radicand 2^60 - s^2
    localparam int SQ_RW     = 63;  // remainder and trial width of the root stages
    localparam int Q13_SHIFT = 17;  // Q30 to Q13

    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [Q13_W-1:0]   ang_q13_t;
    typedef logic signed [PITCH_W-1:0] pitch_q13_t;
    typedef logic signed [ZW-1:0]      ang_q30_t;
    typedef logic signed [CW-1:0]      cordic_t;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic zero;
    } atan_flags_t;

    typedef struct packed {
        logic lock;
        logic neg;
    } pitch_flags_t;

    localparam ang_q30_t ANG_PI_Q30  = 35'sd3373259426;
    localparam ang_q30_t ROUND_Q13   = 35'sd65536;
    localparam ang_q13_t HALF_PI_Q13 = 16'sd12868;

    // atan(2^-i) in Q30 radians
    function automatic ang_q30_t arc_angle(input int idx);
        ang_q30_t a;
        begin
            case (idx)
                0:       a = 35'sd843314857;
                1:       a = 35'sd497837829;
                2:       a = 35'sd263043837;
                3:       a = 35'sd133525159;
                4:       a = 35'sd67021687;
                5:       a = 35'sd33543516;
                6:       a = 35'sd16775851;
                7:       a = 35'sd8388437;
                8:       a = 35'sd4194283;
                9:       a = 35'sd2097149;
                10:      a = 35'sd1048576;
                11:      a = 35'sd524288;
                12:      a = 35'sd262144;
                13:      a = 35'sd131072;
                14:      a = 35'sd65536;
                15:      a = 35'sd32768;
                16:      a = 35'sd16384;
                17:      a = 35'sd8192;
                18:      a = 35'sd4096;
                19:      a = 35'sd2048;
                20:      a = 35'sd1024;
                21:      a = 35'sd512;
                22:      a = 35'sd256;
                23:      a = 35'sd128;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    // input register, normalise stages, CORDIC stages, output register
    function automatic int atan_latency(input int in_w, input int steps);
        int n;
        begin
            n = (steps > ARC_LEN) ? ARC_LEN : steps;
            return 2 + $clog2(in_w + NORM_PAD) + n;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/q2e_atan2.sv -----
// Pipelined atan2: magnitude normalisation stages then one CORDIC vectoring step per stage.
`default_nettype none

module q2e_atan2 #(
    parameter int IN_W  = 34,
    parameter int STEPS = 16
) (
    input  logic                 clk,
    input  logic                 adv,
    input  logic signed [IN_W-1:0] y_in,
    input  logic signed [IN_W-1:0] x_in,
    output q2e_pkg::ang_q13_t    angle
);
    import q2e_pkg::*;

    localparam int FW = IN_W + NORM_PAD;
    localparam int NS = $clog2(FW);
    localparam int NI = (STEPS > ARC_LEN) ? ARC_LEN : STEPS;

    logic [IN_W-1:0] ax_w;
    logic [IN_W-1:0] ay_w;
    logic [FW-1:0]   na_reg [NS+1];
    logic [FW-1:0]   nb_reg [NS+1];
    atan_flags_t     fl_reg [NS+1];
    cordic_t         cx_reg [NI];
    cordic_t         cy_reg [NI];
    ang_q30_t        z_reg  [NI];
    atan_flags_t     fc_reg [NI];
    ang_q30_t        zt;
    ang_q30_t        zr;
    ang_q13_t        angle_reg;

    assign ax_w = x_in[IN_W-1] ? -x_in : x_in;
    assign ay_w = y_in[IN_W-1] ? -y_in : y_in;

    always_ff @(posedge clk) begin
        if (adv) begin
            na_reg[0]      <= {ax_w, {NORM_PAD{1'b0}}};
            nb_reg[0]      <= {ay_w, {NORM_PAD{1'b0}}};
            fl_reg[0].xneg <= x_in[IN_W-1];
            fl_reg[0].yneg <= y_in[IN_W-1];
            fl_reg[0].zero <= (x_in == '0) && (y_in == '0);
        end
    end

    // bring the larger magnitude's top bit to the top of the frame
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int P = 1 << (NS - 1 - j);
        logic [FW-1:0] lead;
        assign lead = na_reg[j] | nb_reg[j];
        always_ff @(posedge clk) begin
            if (adv) begin
                if (lead[FW-1 -: P] == '0) begin
                    na_reg[j+1] <= na_reg[j] << P;
                    nb_reg[j+1] <= nb_reg[j] << P;
                end
                else begin
                    na_reg[j+1] <= na_reg[j];
                    nb_reg[j+1] <= nb_reg[j];
                end
                fl_reg[j+1] <= fl_reg[j];
            end
        end
    end

    for (genvar i = 0; i < NI; i++) begin : g_iter
        cordic_t     cx_src;
        cordic_t     cy_src;
        ang_q30_t    z_src;
        atan_flags_t f_src;
        if (i == 0) begin : g_first
            assign cx_src = {{(CW-NORM_W){1'b0}}, na_reg[NS][FW-1 -: NORM_W]};
            assign cy_src = {{(CW-NORM_W){1'b0}}, nb_reg[NS][FW-1 -: NORM_W]};
            assign z_src  = '0;
            assign f_src  = fl_reg[NS];
        end
        else begin : g_next
            assign cx_src = cx_reg[i-1];
            assign cy_src = cy_reg[i-1];
            assign z_src  = z_reg[i-1];
            assign f_src  = fc_reg[i-1];
        end
        always_ff @(posedge clk) begin
            if (adv) begin
                if (!cy_src[CW-1]) begin
                    cx_reg[i] <= cx_src + (cy_src >>> i);
                    cy_reg[i] <= cy_src - (cx_src >>> i);
                    z_reg[i]  <= z_src + arc_angle(i);
                end
                else begin
                    cx_reg[i] <= cx_src - (cy_src >>> i);
                    cy_reg[i] <= cy_src + (cx_src >>> i);
                    z_reg[i]  <= z_src - arc_angle(i);
                end
                fc_reg[i] <= f_src;
            end
        end
    end

    // fold back into the right quadrant, then round to Q13
    always_comb begin
        zt = z_reg[NI-1];
        if (fc_reg[NI-1].xneg) zt = ANG_PI_Q30 - zt;
        if (fc_reg[NI-1].yneg) zt = -zt;
        if (fc_reg[NI-1].zero) zt = '0;
    end

    assign zr = (zt + ROUND_Q13) >>> Q13_SHIFT;

    always_ff @(posedge clk) begin
        if (adv) begin
            angle_reg <= zr[Q13_W-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

// ----- rtl/core/quaternion_to_euler_unit.sv -----
// Top level of the quaternion to ZYX Euler angle converter.
`default_nettype none

// Takes one quaternion per cycle while in_stall is low and returns roll and yaw in Q2.13 and pitch
// in Q1.13 radians. The depth is set by the pitch path: a multiplier, a 31-stage digit-per-stage
// square root and a CORDIC atan2 with one iteration per stage; roll and yaw are delayed to match.
// The whole pipeline holds while a result beat waits under out_stall, so in_stall follows it.
module quaternion_to_euler_unit #(
    parameter int CORDIC_STEPS   = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  q2e_pkg::quat_t       quat_w,
    input  q2e_pkg::quat_t       quat_x,
    input  q2e_pkg::quat_t       quat_y,
    input  q2e_pkg::quat_t       quat_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output q2e_pkg::ang_q13_t    roll_angle,
    output q2e_pkg::pitch_q13_t  pitch_angle,
    output q2e_pkg::ang_q13_t    yaw_angle,
    output logic                 gimbal_lock
);
    import q2e_pkg::*;

    localparam int FB     = 2 * QUAT_FRAC_BITS;
    localparam int SUM_W  = ((FB > 32) ? FB : 32) + 2;
    localparam int SH_R   = (FB >= 30) ? FB - 30 : 0;
    localparam int SH_L   = (FB < 30) ? 30 - FB : 0;
    localparam int LAT_RY = atan_latency(SUM_W, CORDIC_STEPS);
    localparam int LAT_P  = atan_latency(S30_W, CORDIC_STEPS);
    localparam int PRE_P  = 3 + SQRT_BITS;
    localparam int RY_DLY = PRE_P + LAT_P - LAT_RY;
    localparam int S_DLY  = PRE_P - 1;
    localparam int PF_DLY = PRE_P + LAT_P - 1;
    localparam int TOT    = 2 + PRE_P + LAT_P + 1;
    localparam logic signed [SUM_W-1:0] ONE = {{(SUM_W-1){1'b0}}, 1'b1} << FB;

    function automatic logic signed [SUM_W-1:0] sx(input logic signed [PROD_W-1:0] v);
        return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    logic adv;
    logic [TOT-1:0] vld_reg;

    logic signed [PROD_W-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [PROD_W-1:0] p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;
    logic signed [SUM_W-1:0]  rs_reg, rc_reg, ys_reg, yc_reg, ps_reg;

    logic signed [SUM_W-1:0]  s30_wide;
    logic signed [S30_W-1:0]  s30_next;
    logic [S30_W-1:0]         mag_next;
    logic signed [S30_W-1:0]  s30_reg;
    logic [SQRT_BITS-1:0]     mag_reg;
    pitch_flags_t             pf_reg;
    logic [2*SQRT_BITS-1:0]   sq_reg;
    logic [RAD_W-1:0]         rad_reg;

    logic [SQ_RW-1:0]         rem_reg  [SQRT_BITS];
    logic [SQRT_BITS-1:0]     root_reg [SQRT_BITS];

    logic signed [S30_W-1:0]  s30_dly_reg [S_DLY];
    pitch_flags_t             pf_dly_reg  [PF_DLY];
    ang_q13_t                 roll_dly_reg [RY_DLY];
    ang_q13_t                 yaw_dly_reg  [RY_DLY];

    ang_q13_t                 roll_raw, yaw_raw, pitch_raw, pitch_next;
    logic signed [S30_W-1:0]  root_x;

    ang_q13_t                 roll_reg, yaw_reg;
    pitch_q13_t               pitch_reg;
    logic                     lock_reg;

    // advance every stage unless the result beat is held
    assign adv      = !(vld_reg[TOT-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else if (adv) begin
            vld_reg <= {vld_reg[TOT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            p_wx_reg <= quat_w * quat_x;
            p_yz_reg <= quat_y * quat_z;
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_wz_reg <= quat_w * quat_z;
            p_xy_reg <= quat_x * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_wy_reg <= quat_w * quat_y;
            p_zx_reg <= quat_z * quat_x;

            rs_reg <= (sx(p_wx_reg) + sx(p_yz_reg)) <<< 1;
            rc_reg <= ONE - ((sx(p_xx_reg) + sx(p_yy_reg)) <<< 1);
            ys_reg <= (sx(p_wz_reg) + sx(p_xy_reg)) <<< 1;
            yc_reg <= ONE - ((sx(p_yy_reg) + sx(p_zz_reg)) <<< 1);
            ps_reg <= (sx(p_wy_reg) - sx(p_zx_reg)) <<< 1;
        end
    end

    // pitch sine term to Q30, and its magnitude for the cosine
    assign s30_wide = (ps_reg >>> SH_R) <<< SH_L;
    assign s30_next = s30_wide[S30_W-1:0];
    assign mag_next = s30_next[S30_W-1] ? -s30_next : s30_next;

    always_ff @(posedge clk) begin
        if (adv) begin
            s30_reg     <= s30_next;
            mag_reg     <= mag_next[SQRT_BITS-1:0];
            pf_reg.lock <= (ps_reg >= ONE) || (ps_reg <= -ONE);
            pf_reg.neg  <= ps_reg[SUM_W-1];
            sq_reg      <= mag_reg * mag_reg;
            rad_reg     <= ({{(RAD_W-1){1'b0}}, 1'b1} << (RAD_W - 1)) - sq_reg[RAD_W-1:0];
        end
    end

    // floor square root, one result bit per stage, most significant first
    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
        localparam int B = SQRT_BITS - 1 - k;
        logic [SQ_RW-1:0]     rem_src;
        logic [SQRT_BITS-1:0] root_src;
        logic [SQ_RW-1:0]     trial;
        if (k == 0) begin : g_first
            assign rem_src  = {{(SQ_RW-RAD_W){1'b0}}, rad_reg};
            assign root_src = '0;
        end
        else begin : g_next
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
        end
        assign trial = ({{(SQ_RW-SQRT_BITS){1'b0}}, root_src} << (B + 1))
                     + ({{(SQ_RW-1){1'b0}}, 1'b1} << (2 * B));
        always_ff @(posedge clk) begin
            if (adv) begin
                if (rem_src >= trial) begin
                    rem_reg[k]  <= rem_src - trial;
                    root_reg[k] <= root_src | ({{(SQRT_BITS-1){1'b0}}, 1'b1} << B);
                end
                else begin
                    rem_reg[k]  <= rem_src;
                    root_reg[k] <= root_src;
                end
            end
        end
    end

    // delay lines that line up with the pitch path
    always_ff @(posedge clk) begin
        if (adv) begin
            s30_dly_reg[0]  <= s30_reg;
            pf_dly_reg[0]   <= pf_reg;
            roll_dly_reg[0] <= roll_raw;
            yaw_dly_reg[0]  <= yaw_raw;
            for (int d = 1; d < S_DLY; d++) s30_dly_reg[d] <= s30_dly_reg[d-1];
            for (int d = 1; d < PF_DLY; d++) pf_dly_reg[d] <= pf_dly_reg[d-1];
            for (int d = 1; d < RY_DLY; d++) begin
                roll_dly_reg[d] <= roll_dly_reg[d-1];
                yaw_dly_reg[d]  <= yaw_dly_reg[d-1];
            end
        end
    end

    q2e_atan2 #(.IN_W(SUM_W), .STEPS(CORDIC_STEPS)) u_roll (
        .clk   (clk),
        .adv   (adv),
        .y_in  (rs_reg),
        .x_in  (rc_reg),
        .angle (roll_raw)
    );

    q2e_atan2 #(.IN_W(SUM_W), .STEPS(CORDIC_STEPS)) u_yaw (
        .clk   (clk),
        .adv   (adv),
        .y_in  (ys_reg),
        .x_in  (yc_reg),
        .angle (yaw_raw)
    );

    assign root_x = {1'b0, root_reg[SQRT_BITS-1]};

    q2e_atan2 #(.IN_W(S30_W), .STEPS(CORDIC_STEPS)) u_pitch (
        .clk   (clk),
        .adv   (adv),
        .y_in  (s30_dly_reg[S_DLY-1]),
        .x_in  (root_x),
        .angle (pitch_raw)
    );

    // clamp to +/- pi/2, or pin there on gimbal lock
    always_comb begin
        pitch_next = pitch_raw;
        if (pitch_raw > HALF_PI_Q13) pitch_next = HALF_PI_Q13;
        if (pitch_raw < -HALF_PI_Q13) pitch_next = -HALF_PI_Q13;
        if (pf_dly_reg[PF_DLY-1].lock) begin
            pitch_next = pf_dly_reg[PF_DLY-1].neg ? -HALF_PI_Q13 : HALF_PI_Q13;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            roll_reg  <= roll_dly_reg[RY_DLY-1];
            yaw_reg   <= yaw_dly_reg[RY_DLY-1];
            pitch_reg <= pitch_next[PITCH_W-1:0];
            lock_reg  <= pf_dly_reg[PF_DLY-1].lock;
        end
    end

    assign out_valid   = vld_reg[TOT-1];
    assign roll_angle  = roll_reg;
    assign yaw_angle   = yaw_reg;
    assign pitch_angle = pitch_reg;
    assign gimbal_lock = lock_reg;

endmodule

`default_nettype wire

// ----- rtl/core/q2e_checker.sv -----
// Port-level checks of the quaternion to Euler converter and their bind to the top level.
`default_nettype none

module q2e_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input q2e_pkg::ang_q13_t   roll_angle,
    input q2e_pkg::pitch_q13_t pitch_angle,
    input logic                gimbal_lock
);
    import q2e_pkg::*;

    // a held result beat keeps its roll and pitch values
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(roll_angle) && $stable(pitch_angle))
        else $error("held result beat changed");

    // input is held off exactly while a result beat is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the blocked output");

    // an offered input beat stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input beat withdrawn while stalled");

    a_lock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gimbal_lock |-> pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868)
        else $error("gimbal lock without pitch at pi/2");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868)
        else $error("pitch beyond pi/2");

endmodule

bind quaternion_to_euler_unit q2e_checker u_q2e_checker (.*);

`default_nettype wire

// ----- sim/quaternion_to_euler_unit_tb.sv -----
// Self-checking testbench of the quaternion to ZYX Euler angle converter.
`default_nettype none

module quaternion_to_euler_unit_tb;
    import q2e_pkg::*;

    localparam int FRAC_BITS    = 14;
    localparam int ATAN_STEPS   = 16;
    localparam int LATENCY      = 61;
    localparam int RANDOM_BEATS = 1200;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q13 = 64'sd12868;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               lock;
    } euler_t;

    // atan(2^-i) in Q30 radians
    function automatic longint arctan_step(input int i);
        longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                          16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                          131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        return t[i];
    endfunction

    function automatic longint asr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint vector_angle(input longint sy, input longint sx);
        longint unsigned ax, ay, m;
        longint cx, cy, acc, nx;
        int n;
        ax = sx < 0 ? -sx : sx;
        ay = sy < 0 ? -sy : sy;
        acc = 0;
        n = ATAN_STEPS > 24 ? 24 : ATAN_STEPS;
        if (ax == 0 && ay == 0)
            return 0;
        m = ax > ay ? ax : ay;
        while (m >= (64'd1 << 30))
        begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        cx = ax;
        cy = ay;
        for (int i = 0; i < n; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + asr_floor(cy, i);
                cy = cy - asr_floor(cx, i);
                acc += arctan_step(i);
            end
            else
            begin
                nx = cx - asr_floor(cy, i);
                cy = cy + asr_floor(cx, i);
                acc -= arctan_step(i);
            end
            cx = nx;
        end
        if (sx < 0)
            acc = PI_Q30 - acc;
        if (sy < 0)
            acc = -acc;
        return acc;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint q30_to_q13(input longint a);
        return (a + 65536) >>> 17;
    endfunction

    function automatic euler_t predict_euler(input quat_t qw, qx, qy, qz);
        longint w, x, y, z, one, rs, rc, ys, yc, ps, s30, p, ms;
        longint unsigned c30;
        euler_t e;
        w = qw; x = qx; y = qy; z = qz;
        one = 64'sd1 << (2 * FRAC_BITS);
        rs = 2 * (w * x + y * z);
        rc = one - 2 * (x * x + y * y);
        ys = 2 * (w * z + x * y);
        yc = one - 2 * (y * y + z * z);
        ps = 2 * (w * y - z * x);
        e.roll = 16'(q30_to_q13(vector_angle(rs, rc)));
        e.yaw  = 16'(q30_to_q13(vector_angle(ys, yc)));
        e.lock = 1'b0;
        if (ps >= one || ps <= -one)
        begin
            e.lock = 1'b1;
            p = ps < 0 ? -HALF_PI_Q13 : HALF_PI_Q13;
        end
        else
        begin
            s30 = ps <<< (30 - 2 * FRAC_BITS);
            ms = s30 < 0 ? -s30 : s30;
            c30 = int_root((64'd1 << 60) - ms * ms);
            p = q30_to_q13(vector_angle(s30, c30));
            if (p > HALF_PI_Q13) p = HALF_PI_Q13;
            if (p < -HALF_PI_Q13) p = -HALF_PI_Q13;
        end
        e.pitch = 15'(p);
        return e;
    endfunction

    class euler_scoreboard;
        euler_t pending[$];
        int     errors;

        function void note_quat(input quat_t w, x, y, z);
            pending.push_back(predict_euler(w, x, y, z));
        endfunction

        function void check_angles(input euler_t got);
            euler_t exp_e;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            exp_e = pending.pop_front();
            if (got.roll !== exp_e.roll)
            begin
                $error("roll_angle expected %0d got %0d", exp_e.roll, got.roll);
                errors++;
            end
            if (got.pitch !== exp_e.pitch)
            begin
                $error("pitch_angle expected %0d got %0d", exp_e.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== exp_e.yaw)
            begin
                $error("yaw_angle expected %0d got %0d", exp_e.yaw, got.yaw);
                errors++;
            end
            if (got.lock !== exp_e.lock)
            begin
                $error("gimbal_lock expected %0d got %0d", exp_e.lock, got.lock);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, gimbal_lock;
    quat_t quat_w, quat_x, quat_y, quat_z;
    ang_q13_t roll_angle, yaw_angle;
    pitch_q13_t pitch_angle;

    quaternion_to_euler_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .gimbal_lock(gimbal_lock)
    );

    euler_scoreboard sb = new();
    int  send_idle_pct = 31;
    int  recv_idle_pct = 77;
    bit  hold_off = 0;
    bit  stim_done = 0;
    longint cycles = 0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[quaternion_to_euler_unit] ERROR");
            $finish;
        end
    end

    // receiver: random stall, or one long hold-off counted here when asked
    initial
    begin
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 0;
                out_stall <= 1;
                repeat (4 * LATENCY) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_angles({roll_angle, pitch_angle, yaw_angle, gimbal_lock});

    // offer one beat after random idle gaps, hold it until taken; the caller drops valid at stream pauses
    task automatic send_quat(input quat_t w, x, y, z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
        do @(posedge clk); while (in_stall);
        sb.note_quat(w, x, y, z);
    endtask

    function automatic quat_t rand_comp();
        int r;
        r = $urandom_range(9);
        if (r == 0) return quat_t'($urandom);
        if (r == 1) return 16'sd16384;
        if (r == 2) return -16'sd16384;
        return quat_t'($signed($urandom_range(32768)) - 16384);
    endfunction

    // roughly unit quaternion with random signs
    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = $urandom_range(2000) - 1000.0;
        b = $urandom_range(2000) - 1000.0;
        c = $urandom_range(2000) - 1000.0;
        d = $urandom_range(2000) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 1.0; n = 1.0;
        end
        send_quat(quat_t'($rtoi(16384.0 * a / n)), quat_t'($rtoi(16384.0 * b / n)),
                  quat_t'($rtoi(16384.0 * c / n)), quat_t'($rtoi(16384.0 * d / n)));
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int beats);
        for (int i = 0; i < beats; i++)
        begin
            if ($urandom_range(99) < 75)
                send_unit_quat();
            else
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    initial
    begin
        in_valid = 0;
        quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
        @(posedge rst_n);
        @(posedge clk);
        // identity, extremes, just below gimbal lock both ways, gimbal lock, zero and full-scale bit patterns
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, -11585, 0, 0);
        send_quat(11585, 0, 0, 11585);
        send_quat(11586, 0, 11586, 0);
        send_quat(0, 0, 0, 0);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_quat(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
        send_quat(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, 8192, -8192);
        send_quat(0, 11585, 0, 11585);
        send_quat(1, -1, 1, -1);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, 16384, -16384, 16384);
        in_valid <= 0;
        wait_drained();

        random_phase(RANDOM_BEATS / 3);
        in_valid <= 0;
        send_idle_pct = 77;
        recv_idle_pct = 31;
        // sender pauses until every result is back
        wait_drained();
        random_phase(RANDOM_BEATS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // ask the receiver for a long hold-off while beats keep coming
        hold_off = 1;
        random_phase(RANDOM_BEATS / 3);
        in_valid <= 0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[quaternion_to_euler_unit] OK");
        else
            $display("[quaternion_to_euler_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
